@@ rtl/tangent_frame_rotate_core_assert.svh @@
// Assertion macros for the tangent frame rotation core.
`ifndef TANGENT_FRAME_ROTATE_CORE_ASSERT_SVH
`define TANGENT_FRAME_ROTATE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tangent frame rotate core: implication failed");

// Next-cycle implication, checked outside reset.
`define TFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tangent frame rotate core: next-cycle implication failed");

`endif

@@ rtl/tfr_pkg.sv @@
// Shared types and constants of the tangent frame rotation core.
`timescale 1ns / 1ps
package tfr_pkg;

  typedef struct packed {
    logic advance;
    logic valid;
  } tfr_ctl_t;

  localparam int unsigned HelperNum = 999;
  localparam int unsigned HelperDen = 1000;

endpackage

@@ rtl/tfr_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage, with payload.
`timescale 1ns / 1ps
module tfr_sqrt_pipe #(
  parameter int W  = 16,
  parameter int PW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tfr_pkg::tfr_ctl_t ctl_i,
  input  logic [2*W-1:0]   rad_i,
  input  logic [PW-1:0]    pay_i,
  output logic             valid_o,
  output logic [W-1:0]     root_o,
  output logic [PW-1:0]    pay_o
);
  import tfr_pkg::*;

  localparam int RW = W + 2;

  logic [RW-1:0]  rem_q  [W];
  logic [RW-1:0]  root_q [W];
  logic [2*W-1:0] rad_q  [W];
  logic [PW-1:0]  pay_q  [W];
  logic           vld_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [RW-1:0]  rem_in, root_in, r_try, trial;
    logic [2*W-1:0] rad_in;
    logic [PW-1:0]  p_in;
    logic           v_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign p_in    = pay_i;
      assign v_in    = ctl_i.valid;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign p_in    = pay_q[k-1];
      assign v_in    = vld_q[k-1];
    end

    assign r_try = {rem_in[RW-3:0], rad_in[2*W-1 -: 2]};
    assign trial = {root_in[RW-3:0], 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.advance) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) begin
        if (r_try >= trial) begin
          rem_q[k]  <= r_try - trial;
          root_q[k] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= r_try;
          root_q[k] <= {root_in[RW-2:0], 1'b0};
        end
        rad_q[k] <= {rad_in[2*W-3:0], 2'b00};
        pay_q[k] <= p_in;
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign root_o  = root_q[W-1][W-1:0];
  assign pay_o   = pay_q[W-1];

endmodule

@@ rtl/tfr_div_pipe.sv @@
// Pipelined restoring divider, two numerators over one divisor, one quotient bit per stage.
`timescale 1ns / 1ps
module tfr_div_pipe #(
  parameter int W  = 16,
  parameter int NW = 30,
  parameter int QB = 15,
  parameter int PW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tfr_pkg::tfr_ctl_t ctl_i,
  input  logic [NW-1:0]    num_a_i,
  input  logic [NW-1:0]    num_b_i,
  input  logic [W-1:0]     den_i,
  input  logic [PW-1:0]    pay_i,
  output logic             valid_o,
  output logic [QB-1:0]    quo_a_o,
  output logic [QB-1:0]    quo_b_o,
  output logic [PW-1:0]    pay_o
);
  import tfr_pkg::*;

  logic [NW-1:0] rem_a_q [QB];
  logic [NW-1:0] rem_b_q [QB];
  logic [QB-1:0] quo_a_q [QB];
  logic [QB-1:0] quo_b_q [QB];
  logic [W-1:0]  den_q   [QB];
  logic [PW-1:0] pay_q   [QB];
  logic          vld_q   [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NW-1:0] ra_in, rb_in;
    logic [QB-1:0] qa_in, qb_in;
    logic [W-1:0]  d_in;
    logic [PW-1:0] p_in;
    logic          v_in;
    logic [NW:0]   dsh, ea, eb;

    if (k == 0) begin : g_first
      assign ra_in = num_a_i;
      assign rb_in = num_b_i;
      assign qa_in = '0;
      assign qb_in = '0;
      assign d_in  = den_i;
      assign p_in  = pay_i;
      assign v_in  = ctl_i.valid;
    end else begin : g_next
      assign ra_in = rem_a_q[k-1];
      assign rb_in = rem_b_q[k-1];
      assign qa_in = quo_a_q[k-1];
      assign qb_in = quo_b_q[k-1];
      assign d_in  = den_q[k-1];
      assign p_in  = pay_q[k-1];
      assign v_in  = vld_q[k-1];
    end

    assign dsh = (NW + 1)'(d_in) << (QB - 1 - k);
    assign ea  = {1'b0, ra_in};
    assign eb  = {1'b0, rb_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.advance) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) begin
        if (ea >= dsh) begin
          rem_a_q[k] <= NW'(ea - dsh);
          quo_a_q[k] <= {qa_in[QB-2:0], 1'b1};
        end else begin
          rem_a_q[k] <= ra_in;
          quo_a_q[k] <= {qa_in[QB-2:0], 1'b0};
        end
        if (eb >= dsh) begin
          rem_b_q[k] <= NW'(eb - dsh);
          quo_b_q[k] <= {qb_in[QB-2:0], 1'b1};
        end else begin
          rem_b_q[k] <= rb_in;
          quo_b_q[k] <= {qb_in[QB-2:0], 1'b0};
        end
        den_q[k] <= d_in;
        pay_q[k] <= p_in;
      end
    end
  end

  assign valid_o = vld_q[QB-1];
  assign quo_a_o = quo_a_q[QB-1];
  assign quo_b_o = quo_b_q[QB-1];
  assign pay_o   = pay_q[QB-1];

endmodule

@@ rtl/tangent_frame_rotate_core.sv @@
// Top level of the tangent frame rotation core: front end, frame build and rotation.
//
//   channel   dir  beat contents
//   s_axis    in   vec_x, vec_y, vec_z, norm_x, norm_y, norm_z
//   m_axis    out  out_x, out_y, out_z
//
// One beat enters per cycle while the output register is empty or taken; depth is
// set by the square root (DATA_WIDTH stages) and divider (DATA_WIDTH - 1 stages).
// All stages advance together whenever the output register is empty or taken.
// Reset clears only the valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`include "tangent_frame_rotate_core_assert.svh"
module tangent_frame_rotate_core #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // vec_x, vec_y, vec_z, norm_x, norm_y, norm_z, zero fill
  input  logic [((6*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // out_x, out_y, out_z, zero fill
  output logic [((3*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata_o
);
  import tfr_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int F    = W - 2;
  localparam int NW   = W + F;
  localparam int QB   = F + 1;
  localparam int OTW  = ((3*W+7)/8)*8;
  localparam int SW   = 2*W + 2;
  localparam int PS   = 8*W + 3;
  localparam int PD   = 6*W + 4;

  typedef logic signed [W-1:0]   sw_t;
  typedef logic signed [2*W-1:0] prod_t;
  typedef logic signed [SW-1:0]  sum_t;

  function automatic logic [W-1:0] mag(input sw_t x);
    return x[W-1] ? W'(-x) : W'(x);
  endfunction

  function automatic sw_t sat(input sum_t x);
    sum_t hi, lo;
    hi = SW'($signed({1'b0, {(W-1){1'b1}}}));
    lo = SW'($signed({1'b1, {(W-1){1'b0}}}));
    if (x > hi) return sw_t'(hi);
    if (x < lo) return sw_t'(lo);
    return sw_t'(x);
  endfunction

  function automatic sw_t rnd_sat(input sum_t x);
    sum_t y;
    y = (x + (sum_t'(1) <<< (F - 1))) >>> F;
    return sat(y);
  endfunction

  logic     en;
  logic     out_vld_q;
  tfr_ctl_t ctl_sq, ctl_dv;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Stage 0: field split, helper axis choice, magnitudes.
  sw_t vin [3];
  sw_t nin [3];
  for (genvar i = 0; i < 3; i++) begin : g_in
    assign vin[i] = s_axis_tdata_i[i*W +: W];
    assign nin[i] = s_axis_tdata_i[(3+i)*W +: W];
  end

  logic [W+9:0] hy_lhs, hy_rhs;
  logic         sel_y;
  assign hy_lhs = (W+10)'(mag(nin[1])) * (W+10)'(HelperDen);
  assign hy_rhs = (W+10)'(HelperNum) << F;
  assign sel_y  = hy_lhs < hy_rhs;

  logic           s0_vld_q;
  logic [6*W-1:0] s0_vn_q;
  logic           s0_sel_q, s0_sa_q, s0_sb_q;
  logic [W-1:0]   s0_ma_q, s0_mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_vn_q  <= s_axis_tdata_i[6*W-1:0];
      s0_sel_q <= sel_y;
      s0_sa_q  <= sel_y ? nin[2][W-1] : (nin[1] > 0);
      s0_sb_q  <= sel_y ? (nin[0] > 0) : nin[0][W-1];
      s0_ma_q  <= sel_y ? mag(nin[2]) : mag(nin[1]);
      s0_mb_q  <= mag(nin[0]);
    end
  end

  // Stage 1: squared length.
  logic           s1_vld_q;
  logic [2*W-1:0] s1_sq_q;
  logic [PS-1:0]  s1_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sq_q  <= (2*W)'(s0_ma_q) * (2*W)'(s0_ma_q) + (2*W)'(s0_mb_q) * (2*W)'(s0_mb_q);
      s1_pay_q <= {s0_vn_q, s0_sel_q, s0_sa_q, s0_sb_q, s0_ma_q, s0_mb_q};
    end
  end

  logic          sq_vld;
  logic [W-1:0]  sq_len;
  logic [PS-1:0] sq_pay;

  assign ctl_sq = '{advance: en, valid: s1_vld_q};

  tfr_sqrt_pipe #(.W(W), .PW(PS)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_sq),
    .rad_i   (s1_sq_q),
    .pay_i   (s1_pay_q),
    .valid_o (sq_vld),
    .root_o  (sq_len),
    .pay_o   (sq_pay)
  );

  // Stage 2: rounded numerators.
  logic [W-1:0] sq_ma, sq_mb;
  assign sq_mb = sq_pay[W-1:0];
  assign sq_ma = sq_pay[2*W-1:W];

  logic          s2_vld_q;
  logic [NW-1:0] s2_na_q, s2_nb_q;
  logic [W-1:0]  s2_len_q;
  logic [PD-1:0] s2_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_na_q  <= (NW'(sq_ma) << F) + NW'(sq_len >> 1);
      s2_nb_q  <= (NW'(sq_mb) << F) + NW'(sq_len >> 1);
      s2_len_q <= sq_len;
      s2_pay_q <= {sq_pay[PS-1:2*W], (sq_len == '0)};
    end
  end

  logic          dv_vld;
  logic [QB-1:0] dv_qa, dv_qb;
  logic [PD-1:0] dv_pay;

  assign ctl_dv = '{advance: en, valid: s2_vld_q};

  tfr_div_pipe #(.W(W), .NW(NW), .QB(QB), .PW(PD)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_dv),
    .num_a_i (s2_na_q),
    .num_b_i (s2_nb_q),
    .den_i   (s2_len_q),
    .pay_i   (s2_pay_q),
    .valid_o (dv_vld),
    .quo_a_o (dv_qa),
    .quo_b_o (dv_qb),
    .pay_o   (dv_pay)
  );

  // Stage 3: signed tangent.
  logic dv_zero, dv_sb, dv_sa, dv_sel;
  sw_t  ta, tb;
  assign dv_zero = dv_pay[0];
  assign dv_sb   = dv_pay[1];
  assign dv_sa   = dv_pay[2];
  assign dv_sel  = dv_pay[3];
  assign ta = dv_zero ? '0 : (dv_sa ? -sw_t'(dv_qa) : sw_t'(dv_qa));
  assign tb = dv_zero ? '0 : (dv_sb ? -sw_t'(dv_qb) : sw_t'(dv_qb));

  logic           s3_vld_q;
  logic [6*W-1:0] s3_vn_q;
  sw_t            s3_t_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_vn_q   <= dv_pay[PD-1:4];
      s3_t_q[0] <= ta;
      s3_t_q[1] <= dv_sel ? '0 : tb;
      s3_t_q[2] <= dv_sel ? tb : '0;
    end
  end

  sw_t s3_n [3];
  for (genvar i = 0; i < 3; i++) begin : g_s3n
    assign s3_n[i] = s3_vn_q[(3+i)*W +: W];
  end

  // Stage 4: cross product terms of normal and tangent.
  logic           s4_vld_q;
  logic [6*W-1:0] s4_vn_q;
  sw_t            s4_t_q [3];
  prod_t          s4_p_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_vn_q   <= s3_vn_q;
      s4_t_q    <= s3_t_q;
      s4_p_q[0] <= s3_n[1] * s3_t_q[2];
      s4_p_q[1] <= s3_n[2] * s3_t_q[1];
      s4_p_q[2] <= s3_n[2] * s3_t_q[0];
      s4_p_q[3] <= s3_n[0] * s3_t_q[2];
      s4_p_q[4] <= s3_n[0] * s3_t_q[1];
      s4_p_q[5] <= s3_n[1] * s3_t_q[0];
    end
  end

  // Stage 5: bitangent.
  logic           s5_vld_q;
  logic [6*W-1:0] s5_vn_q;
  sw_t            s5_t_q [3];
  sw_t            s5_b_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_vn_q <= s4_vn_q;
      s5_t_q  <= s4_t_q;
      for (int i = 0; i < 3; i++) begin
        s5_b_q[i] <= rnd_sat(sum_t'(s4_p_q[2*i]) - sum_t'(s4_p_q[2*i+1]));
      end
    end
  end

  sw_t s5_v [3];
  sw_t s5_n [3];
  for (genvar i = 0; i < 3; i++) begin : g_s5vn
    assign s5_v[i] = s5_vn_q[i*W +: W];
    assign s5_n[i] = s5_vn_q[(3+i)*W +: W];
  end

  // Stage 6: rotation products.
  logic  s6_vld_q;
  prod_t s6_pt_q [3];
  prod_t s6_pb_q [3];
  prod_t s6_pn_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_pt_q[i] <= s5_v[0] * s5_t_q[i];
        s6_pb_q[i] <= s5_v[1] * s5_b_q[i];
        s6_pn_q[i] <= s5_v[2] * s5_n[i];
      end
    end
  end

  // Stage 7: sum, round, saturate into the output register.
  sw_t out_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        out_q[i] <= rnd_sat(sum_t'(s6_pt_q[i]) + sum_t'(s6_pb_q[i]) + sum_t'(s6_pn_q[i]));
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OTW'({out_q[2], out_q[1], out_q[0]});

  `TFR_ASSERT_IMPL(a_stall_blocks_input, out_vld_q && !m_axis_tready_i, !s_axis_tready_o)
  `TFR_ASSERT_IMPL(a_tangent_bound, s3_vld_q,
    (mag(s3_t_q[0]) <= (W'(1) << F)) && (mag(s3_t_q[1]) <= (W'(1) << F)) &&
    (mag(s3_t_q[2]) <= (W'(1) << F)))
  `TFR_ASSERT_NEXT(a_zero_tangent_zero_bitangent,
    en && s4_vld_q && s4_t_q[0] == '0 && s4_t_q[1] == '0 && s4_t_q[2] == '0,
    s5_b_q[0] == '0 && s5_b_q[1] == '0 && s5_b_q[2] == '0)

endmodule
